@@ src/e3r_pkg.sv @@
// Package for the serial frame receiver: request types, event codes and
// framing constants. Depends on nothing.
`default_nettype none
package e3r_pkg;

    localparam int unsigned POS_W = 17;
    localparam int unsigned CRC_W = 8;

    localparam logic [7:0]       SYNC_BYTE      = 8'h55;
    localparam logic [7:0]       CRC_POLY_RESET = 8'h07;
    localparam logic [POS_W-1:0] HDR_CRC_POS    = POS_W'(5);
    localparam logic [POS_W-1:0] LAST_LEN_POS   = POS_W'(3);
    localparam logic [POS_W-1:0] FRAME_OVERHEAD = POS_W'(7);

    typedef enum logic [2:0] {
        EV_BYTE     = 3'd0,
        EV_GOOD     = 3'd1,
        EV_HDR_CRC  = 3'd2,
        EV_ZERO_LEN = 3'd3,
        EV_DATA_CRC = 3'd4,
        EV_ABORT    = 3'd5
    } t_event;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       frame_byte;
        logic [POS_W-1:0] byte_position;
        logic [2:0]       event_res;
    } t_out_item;

    typedef struct packed {
        logic hunting;
        logic header_done;
    } t_frame_status;

endpackage
`default_nettype wire

@@ src/esp3_frame_receiver.sv @@
// Serial frame receiver. Results are registered: a result appears in the
// cycle after its request is accepted. Throughput: one request per cycle
// when not stalled; frame state and CRC update are combinational. Requests
// stall only while the result register is full and not drained. Synchronous
// active-low reset returns to sync hunt and sets the polynomial to 0x07.
// Depends on e3r_pkg, e3r_frame_track, e3r_out_reg.
`default_nettype none
module esp3_frame_receiver (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire e3r_pkg::t_in_item  i_in,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output e3r_pkg::t_out_item      o_out,
    input  wire logic               i_cfg_we,
    input  wire logic [7:0]         i_cfg_data
);
    import e3r_pkg::*;

    logic [7:0]    r_poly_q;
    logic          accept;
    logic          has_result;
    logic          can_load;
    t_out_item     result;
    t_frame_status status;

    // polynomial register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly_q <= CRC_POLY_RESET;
        end else if (i_cfg_we) begin
            r_poly_q <= i_cfg_data;
        end
    end

    assign o_ready = can_load;
    assign accept  = i_valid && o_ready;

    e3r_frame_track u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (i_in),
        .i_poly       (r_poly_q),
        .o_has_result (has_result),
        .o_result     (result),
        .o_status     (status)
    );

    e3r_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && has_result),
        .i_data     (result),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_data     (o_out),
        .o_can_load (can_load)
    );

`ifndef SYNTHESIS
    // a held result blocks new requests
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("request taken while result stalled");

    // an abort always leaves the receiver hunting
    a_abort_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.func |=> status.hunting && !status.header_done)
        else $error("abort did not return to hunt");

    // abort results carry a zero byte
    a_abort_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.event_res == EV_ABORT |-> o_out.frame_byte == 8'h00)
        else $error("abort result with nonzero byte");

    // the first byte of a frame is the sync byte
    a_sync_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.byte_position == '0 |->
            o_out.frame_byte == SYNC_BYTE && o_out.event_res == EV_BYTE)
        else $error("frame start without sync byte");
`endif

endmodule
`default_nettype wire

@@ src/e3r_crc8.sv @@
// CRC-8 byte update, MSB first, settable polynomial.
// Depends on e3r_pkg.
`default_nettype none
module e3r_crc8 (
    input  wire logic [e3r_pkg::CRC_W-1:0] i_crc,
    input  wire logic [7:0]                i_data,
    input  wire logic [e3r_pkg::CRC_W-1:0] i_poly,
    output logic      [e3r_pkg::CRC_W-1:0] o_crc
);
    import e3r_pkg::*;

    // eight shift steps over the byte
    always_comb begin
        logic [CRC_W-1:0] c;
        c = i_crc ^ i_data;
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ i_poly;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule
`default_nettype wire

@@ src/e3r_frame_track.sv @@
// Frame tracking state: sync hunt, header collection, CRC checks and
// the result for each accepted request. Depends on e3r_pkg, e3r_crc8.
`default_nettype none
module e3r_frame_track (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire e3r_pkg::t_in_item     i_item,
    input  wire logic [7:0]            i_poly,
    output logic                       o_has_result,
    output e3r_pkg::t_out_item         o_result,
    output e3r_pkg::t_frame_status     o_status
);
    import e3r_pkg::*;

    logic [POS_W-1:0] r_byte_count, n_byte_count;
    logic [POS_W-1:0] r_expected,   n_expected;
    logic [23:0]      r_len_fields, n_len_fields;
    logic [CRC_W-1:0] r_crc,        n_crc;
    logic [CRC_W-1:0] crc_next;
    logic [POS_W-1:0] total;
    logic [POS_W:0]   pos_plus1;
    logic             hunting;

    e3r_crc8 u_crc (
        .i_crc  (r_crc),
        .i_data (i_item.rx_byte),
        .i_poly (i_poly),
        .o_crc  (crc_next)
    );

    assign hunting   = (r_byte_count == '0);
    assign total     = POS_W'(r_len_fields[23:8]) + POS_W'(r_len_fields[7:0]);
    assign pos_plus1 = {1'b0, r_byte_count} + (POS_W+1)'(1);

    // next state and result for this request
    always_comb begin
        n_byte_count = r_byte_count;
        n_expected   = r_expected;
        n_len_fields = r_len_fields;
        n_crc        = r_crc;
        o_has_result = 1'b0;
        o_result.frame_byte    = i_item.rx_byte;
        o_result.byte_position = r_byte_count;
        o_result.event_res     = EV_BYTE;
        if (i_accept) begin
            if (i_item.func) begin
                // abort: only reported inside a frame
                if (!hunting) begin
                    o_has_result       = 1'b1;
                    o_result.frame_byte = '0;
                    o_result.event_res = EV_ABORT;
                    n_byte_count = '0;
                    n_expected   = '0;
                    n_len_fields = '0;
                    n_crc        = '0;
                end
            end else if (!hunting || i_item.rx_byte == SYNC_BYTE) begin
                o_has_result = 1'b1;
                n_byte_count = r_byte_count + POS_W'(1);
                if (hunting) begin
                    n_crc        = '0;
                    n_len_fields = '0;
                    n_expected   = '0;
                end else if (r_expected == '0) begin
                    if (r_byte_count < HDR_CRC_POS) begin
                        if (r_byte_count <= LAST_LEN_POS) begin
                            n_len_fields = {r_len_fields[15:0], i_item.rx_byte};
                        end
                        n_crc = crc_next;
                    end else if (r_crc != i_item.rx_byte) begin
                        o_result.event_res = EV_HDR_CRC;
                        n_byte_count = '0;
                        n_expected   = '0;
                        n_len_fields = '0;
                        n_crc        = '0;
                    end else if (total == '0) begin
                        o_result.event_res = EV_ZERO_LEN;
                        n_byte_count = '0;
                        n_expected   = '0;
                        n_len_fields = '0;
                        n_crc        = '0;
                    end else begin
                        n_expected = total + FRAME_OVERHEAD;
                        n_crc      = '0;
                    end
                end else if (pos_plus1 < {1'b0, r_expected}) begin
                    n_crc = crc_next;
                end else begin
                    // last byte: data CRC
                    o_result.event_res = (r_crc == i_item.rx_byte) ? EV_GOOD : EV_DATA_CRC;
                    n_byte_count = '0;
                    n_expected   = '0;
                    n_len_fields = '0;
                    n_crc        = '0;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_expected   <= '0;
            r_len_fields <= '0;
            r_crc        <= '0;
        end else begin
            r_byte_count <= n_byte_count;
            r_expected   <= n_expected;
            r_len_fields <= n_len_fields;
            r_crc        <= n_crc;
        end
    end

    assign o_status.hunting     = hunting;
    assign o_status.header_done = (r_expected != '0);

endmodule
`default_nettype wire

@@ src/e3r_out_reg.sv @@
// Result register with valid/ready handshake toward the consumer.
// Depends on e3r_pkg.
`default_nettype none
module e3r_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire e3r_pkg::t_out_item i_data,
    input  wire logic               i_ready,
    output logic                    o_valid,
    output e3r_pkg::t_out_item      o_data,
    output logic                    o_can_load
);
    import e3r_pkg::*;

    logic      r_valid;
    t_out_item r_data;

    // free when empty or being drained this cycle
    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

@@ test/esp3_frame_receiver_tb.sv @@
// Testbench for esp3_frame_receiver: sends framed byte streams, stray bytes and aborts,
// predicts every echoed byte and frame event, and checks them in order under random idling.
// Depends on e3r_pkg and the esp3_frame_receiver RTL.
module esp3_frame_receiver_tb;
    import e3r_pkg::*;

    localparam int unsigned HDR_CRC_AT     = 5;          // header CRC byte position
    localparam int unsigned LEN_LAST_AT    = 3;          // last length byte position
    localparam int unsigned OVERHEAD       = 7;          // sync + header + two CRC bytes
    localparam int unsigned PHASE_RESULTS  = 120;
    localparam int unsigned DRAIN_CYCLES   = 4;
    localparam int unsigned RUN_LIMIT      = 5_000_000;
    localparam int          NO_CUT         = -1;
    localparam logic        FUNC_BYTE      = 1'b0;
    localparam logic        FUNC_ABORT     = 1'b1;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    t_in_item   req_item  = '0;
    logic       res_valid;
    logic       res_ready = 1'b0;
    t_out_item  res_item;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_data  = 8'h00;

    // Predicted receiver state
    logic [POS_W-1:0] rx_count;
    logic [POS_W-1:0] frame_len;
    logic [23:0]      len_fields;
    logic [7:0]       crc_acc;
    logic [7:0]       poly_model;

    t_out_item   expected_results[$];
    int unsigned results_predicted = 0;
    int unsigned fail_count        = 0;
    bit          idling_on         = 1'b1;

    esp3_frame_receiver dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (req_valid),
        .o_ready    (req_ready),
        .i_in       (req_item),
        .o_valid    (res_valid),
        .i_ready    (res_ready),
        .o_out      (res_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // MSB-first CRC-8 over one byte
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        int         i;
        c = crc ^ b;
        for (i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = (c << 1) ^ poly;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    function automatic void frame_restart();
        rx_count   = '0;
        frame_len  = '0;
        len_fields = '0;
        crc_acc    = '0;
    endfunction

    // Advance the predicted receiver by one request; returns 1 if a result is due
    function automatic bit track_request(input t_in_item req, output t_out_item res);
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] total;
        t_event           ev;
        res = '0;
        ev  = EV_BYTE;
        if (req.func == FUNC_ABORT) begin
            // abort while hunting is silent
            if (rx_count == '0) return 1'b0;
            res.frame_byte    = 8'h00;
            res.byte_position = rx_count;
            res.event_res     = EV_ABORT;
            frame_restart();
            return 1'b1;
        end
        if (rx_count == '0 && req.rx_byte != SYNC_BYTE) return 1'b0;

        pos      = rx_count;
        rx_count = rx_count + 1'b1;
        if (pos == '0) begin
            crc_acc    = '0;
            len_fields = '0;
            frame_len  = '0;
        end else if (frame_len == '0) begin
            if (pos < HDR_CRC_AT) begin
                if (pos <= LEN_LAST_AT) len_fields = {len_fields[15:0], req.rx_byte};
                crc_acc = crc8_next(crc_acc, req.rx_byte, poly_model);
            end else if (crc_acc != req.rx_byte) begin
                ev = EV_HDR_CRC;
                frame_restart();
            end else begin
                total = POS_W'(len_fields[23:8]) + POS_W'(len_fields[7:0]);
                if (total == '0) begin
                    ev = EV_ZERO_LEN;
                    frame_restart();
                end else begin
                    frame_len = total + POS_W'(OVERHEAD);
                    crc_acc   = '0;
                end
            end
        end else if (int'(pos) + 1 < int'(frame_len)) begin
            crc_acc = crc8_next(crc_acc, req.rx_byte, poly_model);
        end else begin
            // last byte carries the data CRC
            if (crc_acc == req.rx_byte) begin
                ev = EV_GOOD;
            end else begin
                ev = EV_DATA_CRC;
            end
            frame_restart();
        end
        res.frame_byte    = req.rx_byte;
        res.byte_position = pos;
        res.event_res     = ev;
        return 1'b1;
    endfunction

    // Drive one request; predict its result once accepted
    task automatic send_request(input logic func, input logic [7:0] rx_byte);
        int unsigned gap;
        t_out_item   res;
        gap = idling_on ? $urandom_range(0, 5) : 0;
        @(negedge clk);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= '{func: func, rx_byte: rx_byte};
        do begin
            @(posedge clk);
        end while (!req_ready);
        if (track_request(req_item, res)) begin
            expected_results = {expected_results, res};
            results_predicted++;
        end
    endtask

    // Build one frame with the current polynomial and send it, optionally aborted
    task automatic send_frame(input logic [15:0] data_len, input logic [7:0] opt_len,
                              input bit hdr_bad, input bit data_bad, input int cut_at);
        logic [7:0] frame[$];
        logic [7:0] crc;
        logic [7:0] b;
        int         body_len;
        int         i;
        body_len = int'(data_len) + int'(opt_len);
        frame = {frame, SYNC_BYTE};
        frame = {frame, data_len[15:8]};
        frame = {frame, data_len[7:0]};
        frame = {frame, opt_len};
        frame = {frame, 8'($urandom_range(0, 255))};
        crc = '0;
        for (i = 1; i <= 4; i++) crc = crc8_next(crc, frame[i], poly_model);
        if (hdr_bad) crc ^= 8'($urandom_range(1, 255));
        frame = {frame, crc};
        // a bad header or zero length ends the frame at its CRC byte
        if (!hdr_bad && body_len != 0) begin
            crc = '0;
            for (i = 0; i < body_len && (cut_at == NO_CUT || frame.size() <= cut_at); i++)
            begin
                b = 8'($urandom_range(0, 255));
                frame = {frame, b};
                crc = crc8_next(crc, b, poly_model);
            end
            if (data_bad) crc ^= 8'($urandom_range(1, 255));
            frame = {frame, crc};
        end
        foreach (frame[k]) begin
            if (k == cut_at) begin
                send_request(FUNC_ABORT, 8'($urandom_range(0, 255)));
                return;
            end
            send_request(FUNC_BYTE, frame[k]);
        end
    endtask

    // Hold off requests until every predicted result has been checked
    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_polynomial(input logic [7:0] poly);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= poly;
        @(negedge clk);
        cfg_we   <= 1'b0;
        poly_model = poly;
    endtask

    // Mostly well-formed frames, plus broken frames, aborts and line noise
    task automatic send_random_traffic(input int unsigned result_goal);
        int unsigned goal;
        int unsigned kind;
        int unsigned n;
        logic [15:0] dl;
        logic [7:0]  ol;
        goal = results_predicted + result_goal;
        while (results_predicted < goal) begin
            kind = $urandom_range(0, 99);
            dl   = 16'($urandom_range(0, 12));
            ol   = 8'($urandom_range(0, 4));
            if (dl == 0 && ol == 0) dl = 16'd1;
            if (kind < 60) begin
                send_frame(dl, ol, 1'b0, 1'b0, NO_CUT);
            end else if (kind < 68) begin
                send_frame(dl, ol, 1'b1, 1'b0, NO_CUT);
            end else if (kind < 73) begin
                send_frame(16'd0, 8'd0, 1'b0, 1'b0, NO_CUT);
            end else if (kind < 81) begin
                send_frame(dl, ol, 1'b0, 1'b1, NO_CUT);
            end else if (kind < 88) begin
                send_frame(dl, ol, 1'b0, 1'b0, $urandom_range(1, int'(dl) + int'(ol) + 6));
            end else if (kind < 93) begin
                // wide length fields, cut short to keep the run brief
                send_frame(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                           1'b0, 1'b0, $urandom_range(6, 14));
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_request(FUNC_ABORT, 8'($urandom_range(0, 255)));
                    end else begin
                        send_request(FUNC_BYTE, 8'($urandom_range(0, 255)));
                    end
                end
                // a stray sync may have opened a frame: close it
                send_request(FUNC_ABORT, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 19) == 0) idling_on = !idling_on;
        end
    endtask

    task automatic test_directed_cases();
        idling_on = 1'b1;
        send_request(FUNC_BYTE, 8'h00);       // dropped while hunting
        send_request(FUNC_BYTE, 8'hFF);
        send_request(FUNC_ABORT, 8'hFF);      // silent abort while hunting
        send_frame(16'd1, 8'd0, 1'b0, 1'b0, NO_CUT);
        send_frame(16'd0, 8'd0, 1'b0, 1'b0, NO_CUT);
        send_frame(16'd2, 8'd0, 1'b1, 1'b0, NO_CUT);
        send_frame(16'd1, 8'd0, 1'b0, 1'b0, 2);
        wait_drained();
    endtask

    task automatic test_polynomial_sweep();
        logic [7:0] polys[5];
        polys = '{8'h07, 8'h00, 8'hFF, 8'h31, 8'($urandom_range(0, 255))};
        foreach (polys[p]) begin
            wait_drained();
            write_polynomial(polys[p]);
            idling_on = (p != 1);
            send_random_traffic(PHASE_RESULTS);
        end
        wait_drained();
        idling_on = 1'b1;
    endtask

    // One longer frame with data and optional bytes, sent back to back
    task automatic test_long_frame();
        wait_drained();
        write_polynomial(8'($urandom_range(0, 255)));
        idling_on = 1'b0;
        send_frame(16'd40, 8'd10, 1'b0, 1'b0, NO_CUT);
        wait_drained();
        idling_on = 1'b1;
    endtask

    // Result side: random stall before each result while idling is on
    initial begin : result_drain
        int unsigned stall;
        forever begin
            stall = idling_on ? $urandom_range(0, 5) : 0;
            @(negedge clk);
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ready <= 1'b1;
            do begin
                @(posedge clk);
            end while (!(rst_n && res_valid));
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each accepted result with the oldest prediction
    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && res_valid && res_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: byte %0h position %0d event %0d",
                       res_item.frame_byte, res_item.byte_position, res_item.event_res);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("frame_byte", 32'(want.frame_byte), 32'(res_item.frame_byte));
                check_field("byte_position", 32'(want.byte_position),
                            32'(res_item.byte_position));
                check_field("event_res", 32'(want.event_res), 32'(res_item.event_res));
            end
        end
    end

    initial begin
        #RUN_LIMIT;
        $display("status: fail");
        $finish;
    end

    initial begin
        frame_restart();
        poly_model = CRC_POLY_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_polynomial_sweep();
        test_long_frame();

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
